// File: hw/rtl/bsgf_pkg.sv
`default_nettype none

package bsgf_pkg;

    // Payload field widths
    localparam int OPCODE_W     = 3;
    localparam int BIT_INDEX_W  = 8;
    localparam int WORD_INDEX_W = 3;
    localparam int WORD_DATA_W  = 32;
    localparam int POSITION_W   = 8;

    // Configuration port
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam int SIZE_W    = 9;

    typedef logic [REG_IDX_W-1:0] reg_idx_t;
    typedef logic [SIZE_W-1:0]    size_t;

    localparam reg_idx_t REG_BITS_IN_USE = '0;
    localparam size_t    SIZE_RESET      = 9'd256;

    typedef enum logic [OPCODE_W-1:0] {
        OP_SET       = 3'd0,
        OP_GET       = 3'd1,
        OP_FIND_SET  = 3'd2,
        OP_FIND_CLR  = 3'd3,
        OP_AND_WORD  = 3'd4,
        OP_OR_WORD   = 3'd5
    } op_t;

endpackage

`default_nettype wire

// File: hw/rtl/bsgf_ifs.sv
`default_nettype none

// Request channel: one operation per transaction.
interface bsgf_req_if;
    import bsgf_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [OPCODE_W-1:0]     opcode;
    logic [BIT_INDEX_W-1:0]  bit_index;
    logic [WORD_INDEX_W-1:0] word_index;
    logic [WORD_DATA_W-1:0]  word_data;

    modport source (
        output valid, opcode, bit_index, word_index, word_data,
        input  ready
    );

    modport sink (
        input  valid, opcode, bit_index, word_index, word_data,
        output ready
    );
endinterface

// Response channel: one result per request.
interface bsgf_rsp_if;
    import bsgf_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  bit_value;
    logic [POSITION_W-1:0] position;
    logic                  found;
    logic                  range_error;

    modport source (
        output valid, bit_value, position, found, range_error,
        input  ready
    );

    modport sink (
        input  valid, bit_value, position, found, range_error,
        output ready
    );
endinterface

`default_nettype wire

// File: hw/rtl/bitmap_set_get_find_engine_core.sv
`default_nettype none

// Bitmap engine: WORD_COUNT words of WORD_BITS bits, cleared at reset, with
// set, get, find-first-set, find-first-clear and word-wise AND/OR. Only the
// lowest bits_in_use bits (register 0, reset 256, saturating at the bitmap
// size) are valid: set/get beyond them and AND/OR on a word starting beyond
// them flag range_error and change nothing; finds ignore stored bits beyond
// them and report not found (position 0) when no match exists. Every request
// transaction gives exactly one response transaction. Throughput is one
// transaction per cycle while responses are taken: each operation is decoded,
// the whole bitmap searched by one priority encoder and the bitmap register
// updated in the cycle it is accepted, and the result lands in a single
// output register. A new request is taken whenever that register is empty or
// being drained in the same cycle. Write bits_in_use only while idle.
module bitmap_set_get_find_engine_core #(
    parameter int WORD_BITS  = 32,
    parameter int WORD_COUNT = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    bsgf_req_if.sink                     req,
    bsgf_rsp_if.source                   rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bsgf_pkg::PADDR_W-1:0] paddr,
    input  logic [bsgf_pkg::PDATA_W-1:0] pwdata,
    output logic [bsgf_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import bsgf_pkg::*;

    localparam int TOTAL_BITS = WORD_BITS * WORD_COUNT;

    // Bitmap kept flat: bit i lives in word i / WORD_BITS.
    logic [TOTAL_BITS-1:0] bitmap_reg;
    logic [TOTAL_BITS-1:0] bitmap_next;
    size_t                 bits_in_use_reg;

    logic                  rsp_valid_reg;
    logic                  rsp_valid_next;
    logic                  bit_value_reg;
    logic                  bit_value_next;
    logic [POSITION_W-1:0] position_reg;
    logic [POSITION_W-1:0] position_next;
    logic                  found_reg;
    logic                  found_next;
    logic                  range_error_reg;
    logic                  range_error_next;

    logic                  req_acc;
    logic                  cfg_wr;

    // Decode
    op_t  op;
    logic is_set;
    logic is_get;
    logic is_find;
    logic is_and;
    logic is_word;

    // Selects and masks
    logic [TOTAL_BITS-1:0] bit_sel;
    logic [TOTAL_BITS-1:0] size_mask;
    logic [WORD_COUNT-1:0] word_sel;
    logic [WORD_COUNT-1:0] word_ok_vec;
    logic [WORD_BITS-1:0]  data_w;
    logic                  bit_in_range;
    logic                  bit_hit;
    logic                  word_in_range;

    // Find path
    logic [TOTAL_BITS-1:0] find_vec;
    logic [TOTAL_BITS-1:0] find_iso;
    logic                  find_any;
    logic [POSITION_W-1:0] find_pos;

    //--------------------------------------------------------------------
    // Configuration port
    //--------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[PADDR_W-1:2] == REG_BITS_IN_USE);

    always_comb
    begin
        prdata = '0;
        if (paddr[PADDR_W-1:2] == REG_BITS_IN_USE)
        begin
            prdata = PDATA_W'(bits_in_use_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_in_use_reg <= SIZE_RESET;
        end
        else if (cfg_wr)
        begin
            bits_in_use_reg <= pwdata[SIZE_W-1:0];
        end
    end

    //--------------------------------------------------------------------
    // Handshake: a one-entry output register decouples the two sides.
    //--------------------------------------------------------------------
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign req_acc   = req.valid && req.ready;

    //--------------------------------------------------------------------
    // Opcode decode; codes 6 and 7 do nothing and answer all zeros.
    //--------------------------------------------------------------------
    assign op = op_t'(req.opcode);

    always_comb
    begin
        is_set  = 1'b0;
        is_get  = 1'b0;
        is_find = 1'b0;
        is_and  = 1'b0;
        is_word = 1'b0;
        unique case (op)
            OP_SET:      is_set = 1'b1;
            OP_GET:      is_get = 1'b1;
            OP_FIND_SET,
            OP_FIND_CLR: is_find = 1'b1;
            OP_AND_WORD:
            begin
                is_word = 1'b1;
                is_and  = 1'b1;
            end
            OP_OR_WORD:  is_word = 1'b1;
            default:     is_word = 1'b0;
        endcase
    end

    //--------------------------------------------------------------------
    // Per-bit and per-word selects. Because i is always below the bitmap
    // size, i < bits_in_use is the same as i < the saturated size.
    //--------------------------------------------------------------------
    always_comb
    begin
        for (int i = 0; i < TOTAL_BITS; i++)
        begin
            bit_sel[i]   = (BIT_INDEX_W'(i) == req.bit_index) && (i < (1 << BIT_INDEX_W));
            size_mask[i] = (i < int'(bits_in_use_reg));
        end
        for (int w = 0; w < WORD_COUNT; w++)
        begin
            word_sel[w]    = (WORD_INDEX_W'(w) == req.word_index)
                             && (w < (1 << WORD_INDEX_W));
            // a word is usable when its first bit is below the size
            word_ok_vec[w] = size_mask[w*WORD_BITS];
        end
    end

    assign bit_in_range  = |(bit_sel & size_mask);
    assign bit_hit       = |(bit_sel & size_mask & bitmap_reg);
    assign word_in_range = |(word_sel & word_ok_vec);
    assign data_w        = WORD_BITS'(req.word_data);

    //--------------------------------------------------------------------
    // Find: isolate the lowest candidate bit with x & -x, then encode it.
    //--------------------------------------------------------------------
    assign find_vec = ((op == OP_FIND_SET) ? bitmap_reg : ~bitmap_reg) & size_mask;
    assign find_iso = find_vec & (~find_vec + TOTAL_BITS'(1));
    assign find_any = |find_vec;

    always_comb
    begin
        find_pos = '0;
        for (int k = 0; k < POSITION_W; k++)
        begin
            for (int i = 0; i < TOTAL_BITS; i++)
            begin
                if (((i >> k) & 1) == 1)
                begin
                    find_pos[k] = find_pos[k] | find_iso[i];
                end
            end
        end
    end

    //--------------------------------------------------------------------
    // Bitmap update. Bits beyond the size never change.
    //--------------------------------------------------------------------
    always_comb
    begin
        bitmap_next = bitmap_reg;
        for (int w = 0; w < WORD_COUNT; w++)
        begin
            for (int j = 0; j < WORD_BITS; j++)
            begin
                if (is_set && bit_sel[w*WORD_BITS+j] && size_mask[w*WORD_BITS+j])
                begin
                    bitmap_next[w*WORD_BITS+j] = 1'b1;
                end
                if (is_word && word_sel[w] && size_mask[w*WORD_BITS+j])
                begin
                    bitmap_next[w*WORD_BITS+j] = is_and
                        ? (bitmap_reg[w*WORD_BITS+j] & data_w[j])
                        : (bitmap_reg[w*WORD_BITS+j] | data_w[j]);
                end
            end
        end
    end

    //--------------------------------------------------------------------
    // Result
    //--------------------------------------------------------------------
    assign bit_value_next   = is_get && bit_hit;
    assign found_next       = is_find && find_any;
    assign position_next    = (is_find && find_any) ? find_pos : '0;
    assign range_error_next = ((is_set || is_get) && !bit_in_range)
                              || (is_word && !word_in_range);

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (req_acc)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bitmap_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (req_acc)
            begin
                bitmap_reg <= bitmap_next;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            bit_value_reg   <= bit_value_next;
            position_reg    <= position_next;
            found_reg       <= found_next;
            range_error_reg <= range_error_next;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.bit_value   = bit_value_reg;
    assign rsp.position    = position_reg;
    assign rsp.found       = found_reg;
    assign rsp.range_error = range_error_reg;

    //--------------------------------------------------------------------
    // Assertions
    //--------------------------------------------------------------------
    // Finds never report a range error and always produce a response.
    a_find_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc && (op == OP_FIND_SET || op == OP_FIND_CLR)
        |=> rsp.valid && !rsp.range_error)
        else $error("find transaction without clean response");

    // An in-range set leaves the addressed bit set.
    a_set_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc && is_set && bit_in_range
        |=> |(bitmap_reg & $past(bit_sel)))
        else $error("set did not reach the bitmap");

    // The bitmap only changes on an accepted transaction.
    a_bitmap_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !req_acc |=> $stable(bitmap_reg))
        else $error("bitmap changed without a transaction");

    // A found position must point at a valid bit.
    a_found_in_size: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc && found_next |-> |(find_iso & size_mask))
        else $error("find reported a bit beyond the size");

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`default_nettype none

// Bitmap engine testbench.
// A directed table comes first: reset state, extremes, spare opcodes, an
// empty bitmap, a size past the bitmap and a one-bit bitmap. Random
// operations follow, in phases with different bits_in_use settings. A shadow
// bitmap in this module predicts every response not typed into the table,
// and responses are checked in order.
module tb_top;
    import bsgf_pkg::*;

    localparam int WORD_BITS  = 32;
    localparam int WORD_COUNT = 8;
    localparam int TOTAL_BITS = WORD_BITS * WORD_COUNT;

    // opcodes the block does not use; it must answer them with all zeros
    localparam logic [OPCODE_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OPCODE_W-1:0] OP_SPARE_HI = 3'd7;

    // kinds of directed table rows
    localparam logic ROW_OP   = 1'b0;
    localparam logic ROW_SIZE = 1'b1;

    localparam int PHASES         = 10;
    localparam int OPS_PER_PHASE  = 40;
    localparam int LONG_HOLD      = 60;
    localparam int SETTLE_CYCLES  = 3;
    localparam int MAX_REPORTED   = 10;

    typedef struct packed {
        logic [OPCODE_W-1:0]     opcode;
        logic [BIT_INDEX_W-1:0]  bit_index;
        logic [WORD_INDEX_W-1:0] word_index;
        logic [WORD_DATA_W-1:0]  word_data;
    } bitmap_op_t;

    typedef struct packed {
        logic                  bit_value;
        logic [POSITION_W-1:0] position;
        logic                  found;
        logic                  range_error;
    } bitmap_res_t;

    // a directed row either rewrites bits_in_use or issues one operation;
    // typed marks rows whose response is written out here rather than predicted
    typedef struct packed {
        logic        kind;
        size_t       size_val;
        bitmap_op_t  op;
        logic        typed;
        bitmap_res_t res;
    } dir_row_t;

    localparam bitmap_res_t RES_NONE    = '0;
    localparam bitmap_res_t RES_RANGE   = '{1'b0, 8'd0, 1'b0, 1'b1};
    localparam bitmap_res_t RES_AT_ZERO = '{1'b0, 8'd0, 1'b1, 1'b0};

    localparam int DIR_ROWS = 29;

    logic clk = 1'b0;
    logic rst_n;

    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    wire  [PDATA_W-1:0]   prdata;
    wire                  pready;

    bsgf_req_if req_ch ();
    bsgf_rsp_if rsp_ch ();

    bitmap_set_get_find_engine_core #(
        .WORD_BITS  (WORD_BITS),
        .WORD_COUNT (WORD_COUNT)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 clk = ~clk;

    // Shadow copy of the block state, advanced at each accepted request.
    logic [WORD_BITS-1:0] shadow_words [WORD_COUNT];
    size_t                shadow_size;

    // Responses still owed by the block, oldest first.
    bitmap_res_t pending_results [$];

    int fail_cnt = 0;
    int sent_cnt = 0;
    int rcvd_cnt = 0;

    dir_row_t dir_tbl [DIR_ROWS];

    // Size actually in force: anything past the bitmap saturates.
    function automatic int unsigned live_bits();
        return (shadow_size > TOTAL_BITS) ? TOTAL_BITS : int'(shadow_size);
    endfunction

    // Applies one operation to the shadow bitmap and returns its response.
    function automatic bitmap_res_t bitmap_predict(bitmap_op_t op);
        bitmap_res_t          r;
        int unsigned          lim;
        int unsigned          base;
        int unsigned          i;
        logic                 want;
        logic [WORD_BITS-1:0] mask;
        logic [WORD_BITS-1:0] merged;
        r   = RES_NONE;
        lim = live_bits();
        case (op.opcode)
            OP_SET, OP_GET:
            begin
                if (op.bit_index >= lim)
                    r.range_error = 1'b1;
                else if (op.opcode == OP_SET)
                    shadow_words[op.bit_index / WORD_BITS][op.bit_index % WORD_BITS] = 1'b1;
                else
                    r.bit_value = shadow_words[op.bit_index / WORD_BITS][op.bit_index % WORD_BITS];
            end
            OP_FIND_SET, OP_FIND_CLR:
            begin
                // stored bits at or above the size never match
                want = (op.opcode == OP_FIND_SET);
                for (i = 0; i < lim && !r.found; i++)
                begin
                    if (shadow_words[i / WORD_BITS][i % WORD_BITS] == want)
                    begin
                        r.found    = 1'b1;
                        r.position = POSITION_W'(i);
                    end
                end
            end
            OP_AND_WORD, OP_OR_WORD:
            begin
                base = op.word_index * WORD_BITS;
                if (base >= lim)
                    r.range_error = 1'b1;
                else
                begin
                    // only bits below the size may change
                    mask = (lim - base >= WORD_BITS) ? '1
                                                     : ((32'd1 << (lim - base)) - 32'd1);
                    merged = (op.opcode == OP_AND_WORD)
                           ? (shadow_words[op.word_index] & op.word_data)
                           : (shadow_words[op.word_index] | op.word_data);
                    shadow_words[op.word_index] =
                        (shadow_words[op.word_index] & ~mask) | (merged & mask);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Random operation, weighted toward sets and ORs so that finds see a
    // bitmap that fills up, with indices mostly inside the live size.
    function automatic bitmap_op_t random_op();
        bitmap_op_t  op;
        int unsigned sel;
        int unsigned lim;
        lim = live_bits();
        sel = $urandom_range(99, 0);
        if (sel < 30)
            op.opcode = OP_SET;
        else if (sel < 45)
            op.opcode = OP_GET;
        else if (sel < 57)
            op.opcode = OP_FIND_SET;
        else if (sel < 69)
            op.opcode = OP_FIND_CLR;
        else if (sel < 79)
            op.opcode = OP_AND_WORD;
        else if (sel < 94)
            op.opcode = OP_OR_WORD;
        else
            op.opcode = ($urandom_range(1, 0) != 0) ? OP_SPARE_HI : OP_SPARE_LO;
        if (lim > 0 && $urandom_range(3, 0) != 0)
            op.bit_index = BIT_INDEX_W'($urandom_range(lim - 1, 0));
        else
            op.bit_index = BIT_INDEX_W'($urandom_range(255, 0));
        op.word_index = WORD_INDEX_W'($urandom_range(WORD_COUNT - 1, 0));
        case ($urandom_range(3, 0))
            0:       op.word_data = '1;
            1:       op.word_data = '0;
            default: op.word_data = $urandom;
        endcase
        return op;
    endfunction

    // One request transaction. The handshake is sampled at the falling edge,
    // where ready and valid are settled, and takes effect at the next rising
    // edge. The prediction is made in acceptance order.
    task automatic issue_op(bitmap_op_t op, logic typed, bitmap_res_t typed_res);
        int          gap;
        logic        hs;
        bitmap_res_t pred;
        // every fourth run of 32 requests goes back to back
        gap = (((sent_cnt >> 5) & 3) == 3) ? 0 : $urandom_range(4, 0);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.opcode     <= op.opcode;
        req_ch.bit_index  <= op.bit_index;
        req_ch.word_index <= op.word_index;
        req_ch.word_data  <= op.word_data;
        do
        begin
            @(negedge clk);
            hs = req_ch.ready;
            @(posedge clk);
        end
        while (!hs);
        pred = bitmap_predict(op);
        pending_results.push_back(typed ? typed_res : pred);
        sent_cnt++;
    endtask

    // Stop offering and let every owed response come back before a
    // register write; the extra cycles cover the output register.
    task automatic drain_block();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Setup cycle then access cycle; the register takes the value at the
    // edge that ends the access cycle with pready high.
    task automatic write_bits_in_use(size_t val);
        logic hs;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_BITS_IN_USE, 2'b00};
        pwdata  <= PDATA_W'(val);
        @(posedge clk);
        penable <= 1'b1;
        do
        begin
            @(negedge clk);
            hs = pready;
            @(posedge clk);
        end
        while (!hs);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        shadow_size = val;
    endtask

    // Directed table. Rows walk from the reset state through a full bitmap
    // word, spare opcodes, an empty bitmap, a size past the bitmap and a
    // one-bit bitmap with stale bits left above it.
    initial
    begin
        dir_tbl = '{
            '{ROW_OP,   9'd0,   '{OP_GET,      8'd0,   3'd0, 32'h0},         1'b1, RES_NONE},
            '{ROW_OP,   9'd0,   '{OP_FIND_SET, 8'd0,   3'd0, 32'h0},         1'b1, RES_NONE},
            '{ROW_OP,   9'd0,   '{OP_FIND_CLR, 8'd0,   3'd0, 32'h0},         1'b1, RES_AT_ZERO},
            '{ROW_OP,   9'd0,   '{OP_SET,      8'd255, 3'd0, 32'h0},         1'b1, RES_NONE},
            '{ROW_OP,   9'd0,   '{OP_GET,      8'd255, 3'd0, 32'h0},         1'b1,
              '{1'b1, 8'd0, 1'b0, 1'b0}},
            '{ROW_OP,   9'd0,   '{OP_FIND_SET, 8'd0,   3'd0, 32'h0},         1'b1,
              '{1'b0, 8'd255, 1'b1, 1'b0}},
            '{ROW_OP,   9'd0,   '{OP_SET,      8'd0,   3'd0, 32'h0},         1'b0, RES_NONE},
            '{ROW_OP,   9'd0,   '{OP_OR_WORD,  8'd0,   3'd7, 32'hFFFF_FFFF}, 1'b0, RES_NONE},
            '{ROW_OP,   9'd0,   '{OP_FIND_CLR, 8'd0,   3'd0, 32'h0},         1'b0, RES_NONE},
            '{ROW_OP,   9'd0,   '{OP_AND_WORD, 8'd0,   3'd0, 32'h0},         1'b0, RES_NONE},
            '{ROW_OP,   9'd0,   '{OP_AND_WORD, 8'd0,   3'd7, 32'h5555_5555}, 1'b0, RES_NONE},
            '{ROW_OP,   9'd0,   '{OP_OR_WORD,  8'd0,   3'd3, 32'hA5A5_A5A5}, 1'b0, RES_NONE},
            '{ROW_OP,   9'd0,   '{OP_SPARE_LO, 8'd255, 3'd7, 32'hFFFF_FFFF}, 1'b1, RES_NONE},
            '{ROW_OP,   9'd0,   '{OP_SPARE_HI, 8'd255, 3'd7, 32'hFFFF_FFFF}, 1'b1, RES_NONE},
            // empty bitmap
            '{ROW_SIZE, 9'd0,   '{3'd0, 8'd0, 3'd0, 32'h0},                  1'b0, RES_NONE},
            '{ROW_OP,   9'd0,   '{OP_SET,      8'd0,   3'd0, 32'h0},         1'b1, RES_RANGE},
            '{ROW_OP,   9'd0,   '{OP_GET,      8'd0,   3'd0, 32'h0},         1'b1, RES_RANGE},
            '{ROW_OP,   9'd0,   '{OP_FIND_SET, 8'd0,   3'd0, 32'h0},         1'b1, RES_NONE},
            '{ROW_OP,   9'd0,   '{OP_FIND_CLR, 8'd0,   3'd0, 32'h0},         1'b1, RES_NONE},
            '{ROW_OP,   9'd0,   '{OP_OR_WORD,  8'd0,   3'd0, 32'hFFFF_FFFF}, 1'b1, RES_RANGE},
            // largest register value, saturates to the whole bitmap
            '{ROW_SIZE, 9'd511, '{3'd0, 8'd0, 3'd0, 32'h0},                  1'b0, RES_NONE},
            '{ROW_OP,   9'd0,   '{OP_GET,      8'd255, 3'd0, 32'h0},         1'b0, RES_NONE},
            '{ROW_OP,   9'd0,   '{OP_FIND_SET, 8'd0,   3'd0, 32'h0},         1'b0, RES_NONE},
            // one valid bit, stale bits above it must be ignored
            '{ROW_SIZE, 9'd1,   '{3'd0, 8'd0, 3'd0, 32'h0},                  1'b0, RES_NONE},
            '{ROW_OP,   9'd0,   '{OP_OR_WORD,  8'd0,   3'd0, 32'hFFFF_FFFF}, 1'b1, RES_NONE},
            '{ROW_OP,   9'd0,   '{OP_FIND_CLR, 8'd0,   3'd0, 32'h0},         1'b1, RES_NONE},
            '{ROW_OP,   9'd0,   '{OP_GET,      8'd1,   3'd0, 32'h0},         1'b1, RES_RANGE},
            '{ROW_OP,   9'd0,   '{OP_AND_WORD, 8'd0,   3'd1, 32'h0},         1'b1, RES_RANGE},
            '{ROW_OP,   9'd0,   '{OP_FIND_SET, 8'd0,   3'd0, 32'h0},         1'b1, RES_AT_ZERO}
        };
    end

    // Stimulus: reset, directed table, random phases, then the wind-down.
    initial
    begin
        size_t phase_sizes [PHASES];
        int    ph;
        int    k;
        rst_n             <= 1'b0;
        psel              <= 1'b0;
        penable           <= 1'b0;
        pwrite            <= 1'b0;
        paddr             <= '0;
        pwdata            <= '0;
        req_ch.valid      <= 1'b0;
        req_ch.opcode     <= '0;
        req_ch.bit_index  <= '0;
        req_ch.word_index <= '0;
        req_ch.word_data  <= '0;
        foreach (shadow_words[w])
            shadow_words[w] = '0;
        shadow_size = SIZE_RESET;
        // full size, a word-straddling size, one bit, past the bitmap, empty,
        // and two random picks on either side of the saturation point
        phase_sizes = '{9'd256, 9'd37, 9'd1, 9'd511, 9'd0,
                        9'd200, 9'd0, 9'd256, 9'd64, 9'd0};
        phase_sizes[6] = size_t'($urandom_range(256, 1));
        phase_sizes[9] = size_t'($urandom_range(511, 257));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < DIR_ROWS; k++)
        begin
            if (dir_tbl[k].kind == ROW_SIZE)
            begin
                drain_block();
                write_bits_in_use(dir_tbl[k].size_val);
            end
            else
                issue_op(dir_tbl[k].op, dir_tbl[k].typed, dir_tbl[k].res);
        end

        for (ph = 0; ph < PHASES; ph++)
        begin
            drain_block();
            write_bits_in_use(phase_sizes[ph]);
            for (k = 0; k < OPS_PER_PHASE; k++)
                issue_op(random_op(), 1'b0, RES_NONE);
        end

        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fail_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Response side: random stalls per transaction, back-to-back runs, and
    // two long hold-offs so the output register fills and the request side
    // sees ready drop while requests keep coming.
    initial
    begin
        bitmap_res_t got;
        bitmap_res_t want;
        int          stall;
        logic        hs;
        rsp_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (rcvd_cnt == 140 || rcvd_cnt == 300)
                stall = LONG_HOLD;
            else if (((rcvd_cnt >> 5) & 3) == 1)
                stall = 0;
            else
                stall = $urandom_range(4, 0);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do
            begin
                @(negedge clk);
                hs  = rsp_ch.valid;
                got = '{rsp_ch.bit_value, rsp_ch.position, rsp_ch.found, rsp_ch.range_error};
                @(posedge clk);
            end
            while (!hs);
            rcvd_cnt++;
            if (pending_results.size() == 0)
            begin
                fail_cnt++;
                if (fail_cnt <= MAX_REPORTED)
                    $display("ERROR: unexpected response transaction %0d", rcvd_cnt);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    fail_cnt++;
                    if (fail_cnt <= MAX_REPORTED)
                        $display({"ERROR: response %0d expected bit_value %0b position %0d ",
                                  "found %0b range_error %0b, got %0b %0d %0b %0b"},
                                 rcvd_cnt, want.bit_value, want.position, want.found,
                                 want.range_error, got.bit_value, got.position, got.found,
                                 got.range_error);
                end
            end
        end
    end

    // Watchdog: stops a hung run and reports it as failed.
    initial
    begin
        #400000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
